@@ rtl/assert_macros.svh @@
// Assertion macros shared by the waypoint heading controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ rtl/whc_pkg.sv @@
// Types, constants and the arctangent table for the waypoint heading controller.
`default_nettype none

package whc_pkg;

    localparam int POS_W    = 24;
    localparam int ANG_W    = 16;
    localparam int TS_W     = 32;
    localparam int GAIN_W   = 16;
    localparam int SPEED_W  = 16;
    localparam int RAD_W    = 24;
    localparam int DIFF_W   = POS_W + 1;
    localparam int XY_W     = 28;
    localparam int ACC_W    = 32;
    localparam int MUL_W    = 26;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int D2_W     = 50;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int IN_W     = 96;
    localparam int OUT_W    = 40;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_MAX       = 24;
    localparam int ITER_W           = $clog2(CORDIC_MAX);

    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd256;
    localparam logic [ACC_W-1:0]  HALF_TURN = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_TARGET_X,
        REG_TARGET_Y,
        REG_THETA_GAIN,
        REG_DRIVE_SPEED,
        REG_SLOW_RADIUS,
        REG_DONE_RADIUS,
        REG_DWELL_MS
    } reg_idx_t;

    typedef struct packed {
        logic signed [POS_W-1:0]   target_x;
        logic signed [POS_W-1:0]   target_y;
        logic        [GAIN_W-1:0]  theta_gain;
        logic signed [SPEED_W-1:0] drive_speed;
        logic        [RAD_W-1:0]   slow_radius;
        logic        [RAD_W-1:0]   done_radius;
        logic        [TS_W-1:0]    dwell_ms;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_DX,
        ST_SQ_DY,
        ST_SQ_SLOW,
        ST_SQ_DONE,
        ST_DWELL,
        ST_ROT,
        ST_ITER,
        ST_GAIN,
        ST_SAT,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_DX,
        MUL_DY,
        MUL_SLOW,
        MUL_DONE,
        MUL_ERR
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        mul_sel_t mul_sel;
        logic     d2_load;
        logic     d2_acc;
        logic     far_load;
        logic     dwell_upd;
        logic     cordic_init;
        logic     cordic_step;
        logic     rate_load;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic far;
        logic cordic_last;
        logic out_free;
    } sts_t;

    // atan(2^-i), 2^32 = full turn, rounded
    function automatic logic [ACC_W-1:0] atan_lut(input logic [ITER_W-1:0] i);
        logic [ACC_W-1:0] v;
        case (i)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/whc_regs.sv @@
// Configuration register file with its APB-style access port.
`default_nettype none

module whc_regs
    import whc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    localparam cfg_t CFG_RST = '{
        target_x:    '0,
        target_y:    '0,
        theta_gain:  GAIN_RST,
        drive_speed: '0,
        slow_radius: '0,
        done_radius: '0,
        dwell_ms:    '0
    };

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_TARGET_X:    cfg_next.target_x    = pwdata[POS_W-1:0];
                REG_TARGET_Y:    cfg_next.target_y    = pwdata[POS_W-1:0];
                REG_THETA_GAIN:  cfg_next.theta_gain  = pwdata[GAIN_W-1:0];
                REG_DRIVE_SPEED: cfg_next.drive_speed = pwdata[SPEED_W-1:0];
                REG_SLOW_RADIUS: cfg_next.slow_radius = pwdata[RAD_W-1:0];
                REG_DONE_RADIUS: cfg_next.done_radius = pwdata[RAD_W-1:0];
                REG_DWELL_MS:    cfg_next.dwell_ms    = pwdata[TS_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TARGET_X:    prdata = {8'd0, cfg_reg.target_x};
            REG_TARGET_Y:    prdata = {8'd0, cfg_reg.target_y};
            REG_THETA_GAIN:  prdata = {16'd0, cfg_reg.theta_gain};
            REG_DRIVE_SPEED: prdata = {16'd0, cfg_reg.drive_speed};
            REG_SLOW_RADIUS: prdata = {8'd0, cfg_reg.slow_radius};
            REG_DONE_RADIUS: prdata = {8'd0, cfg_reg.done_radius};
            REG_DWELL_MS:    prdata = cfg_reg.dwell_ms;
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/whc_ctrl.sv @@
// Sequencing state machine for the waypoint heading controller.
`default_nettype none
`include "assert_macros.svh"

module whc_ctrl
    import whc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  sts_t      sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_DX;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SQ_DX;
                end
            end
            ST_SQ_DX: begin
                cmd.mul_sel = MUL_DX;
                state_next  = ST_SQ_DY;
            end
            ST_SQ_DY: begin
                cmd.mul_sel = MUL_DY;
                cmd.d2_load = 1'b1;
                state_next  = ST_SQ_SLOW;
            end
            ST_SQ_SLOW: begin
                cmd.mul_sel = MUL_SLOW;
                cmd.d2_acc  = 1'b1;
                state_next  = ST_SQ_DONE;
            end
            ST_SQ_DONE: begin
                cmd.mul_sel  = MUL_DONE;
                cmd.far_load = 1'b1;
                state_next   = ST_DWELL;
            end
            ST_DWELL: begin
                cmd.dwell_upd = 1'b1;
                state_next    = sts.far ? ST_ROT : ST_OUT;
            end
            ST_ROT: begin
                cmd.cordic_init = 1'b1;
                state_next      = ST_ITER;
            end
            ST_ITER: begin
                cmd.cordic_step = 1'b1;
                if (sts.cordic_last) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                cmd.mul_sel = MUL_ERR;
                state_next  = ST_SAT;
            end
            ST_SAT: begin
                cmd.rate_load = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `ASSERT_NEXT(a_accept_starts, aclk, aresetn, cmd.load_in, state_reg == ST_SQ_DX)
    `ASSERT_IMPL(a_out_load_free, aclk, aresetn, cmd.out_load, sts.out_free)
    `ASSERT_NEXT(a_iter_exit, aclk, aresetn, (state_reg == ST_ITER) && sts.cordic_last, state_reg == ST_GAIN)

endmodule

`default_nettype wire

@@ rtl/whc_dp.sv @@
// Datapath: shared multiplier, distance compares, dwell timer, CORDIC and output word.
`default_nettype none
`include "assert_macros.svh"

module whc_dp
    import whc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  cmd_t                   cmd,
    input  cfg_t                   cfg,
    input  wire logic [POS_W-1:0]  in_pos_x,
    input  wire logic [POS_W-1:0]  in_pos_y,
    input  wire logic [ANG_W-1:0]  in_heading,
    input  wire logic [TS_W-1:0]   in_timestamp_ms,
    output sts_t                   sts,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [OUT_W-1:0]  m_tdata
);

    localparam int NSTEP = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(NSTEP - 1);

    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic        [ANG_W-1:0]  head_reg;
    logic        [TS_W-1:0]   ts_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic        [D2_W-1:0]   d2_reg;
    logic                     far_reg;
    logic                     dwell_active_reg;
    logic        [TS_W-1:0]   dwell_start_reg;
    logic                     done_reg;
    logic signed [XY_W-1:0]   x_reg, y_reg;
    logic        [ACC_W-1:0]  acc_reg;
    logic        [ITER_W-1:0] iter_reg;
    logic        [ANG_W-1:0]  rate_reg;
    logic                     out_valid_reg;
    logic        [OUT_W-1:0]  out_data_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic        [D2_W-1:0]   rad2;
    logic                     near;
    logic        [TS_W-1:0]   start_sel, elapsed;
    logic signed [XY_W-1:0]   dx_ext, dy_ext, xs, ys;
    logic        [ACC_W-1:0]  acc_rnd;
    logic        [ANG_W-1:0]  err;
    logic signed [33:0]       rnd, shifted;
    logic        [ANG_W-1:0]  rate_sat;

    // operand select for the shared multiplier
    always_comb begin
        case (cmd.mul_sel)
            MUL_DX: begin
                mul_a = {dx_reg[DIFF_W-1], dx_reg};
                mul_b = {dx_reg[DIFF_W-1], dx_reg};
            end
            MUL_DY: begin
                mul_a = {dy_reg[DIFF_W-1], dy_reg};
                mul_b = {dy_reg[DIFF_W-1], dy_reg};
            end
            MUL_SLOW: begin
                mul_a = {2'b00, cfg.slow_radius};
                mul_b = {2'b00, cfg.slow_radius};
            end
            MUL_DONE: begin
                mul_a = {2'b00, cfg.done_radius};
                mul_b = {2'b00, cfg.done_radius};
            end
            MUL_ERR: begin
                mul_a = {{(MUL_W-ANG_W){err[ANG_W-1]}}, err};
                mul_b = {{(MUL_W-GAIN_W){1'b0}}, cfg.theta_gain};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rad2 = prod_reg[D2_W-1:0];
    assign near = (d2_reg <= rad2);

    // elapsed time counts from this sample when the dwell has just begun
    assign start_sel = dwell_active_reg ? dwell_start_reg : ts_reg;
    assign elapsed   = ts_reg - start_sel;

    assign dx_ext = {{(XY_W-DIFF_W){dx_reg[DIFF_W-1]}}, dx_reg};
    assign dy_ext = {{(XY_W-DIFF_W){dy_reg[DIFF_W-1]}}, dy_reg};
    assign xs     = x_reg >>> iter_reg;
    assign ys     = y_reg >>> iter_reg;

    assign acc_rnd = acc_reg + 32'h0000_8000;
    assign err     = acc_rnd[ACC_W-1:ACC_W-ANG_W] - head_reg;

    assign rnd     = prod_reg[33:0] + 34'sd128;
    assign shifted = rnd >>> 8;

    always_comb begin
        if (shifted > 34'sd32767) begin
            rate_sat = 16'h7FFF;
        end else if (shifted < -34'sd32768) begin
            rate_sat = 16'h8000;
        end else begin
            rate_sat = shifted[ANG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load_in) begin
            dx_reg   <= {cfg.target_x[POS_W-1], cfg.target_x} - {in_pos_x[POS_W-1], in_pos_x};
            dy_reg   <= {cfg.target_y[POS_W-1], cfg.target_y} - {in_pos_y[POS_W-1], in_pos_y};
            head_reg <= in_heading;
            ts_reg   <= in_timestamp_ms;
        end
        if (cmd.d2_load) begin
            d2_reg <= rad2;
        end else if (cmd.d2_acc) begin
            d2_reg <= d2_reg + rad2;
        end
        if (cmd.far_load) begin
            far_reg <= (d2_reg > rad2);
        end
        if (cmd.cordic_init) begin
            // half-turn pre-rotation into the right half plane
            if (dx_reg[DIFF_W-1]) begin
                x_reg   <= -dx_ext;
                y_reg   <= -dy_ext;
                acc_reg <= HALF_TURN;
            end else begin
                x_reg   <= dx_ext;
                y_reg   <= dy_ext;
                acc_reg <= '0;
            end
            iter_reg <= '0;
        end else if (cmd.cordic_step) begin
            if (!y_reg[XY_W-1]) begin
                x_reg   <= x_reg + ys;
                y_reg   <= y_reg - xs;
                acc_reg <= acc_reg + atan_lut(iter_reg);
            end else begin
                x_reg   <= x_reg - ys;
                y_reg   <= y_reg + xs;
                acc_reg <= acc_reg - atan_lut(iter_reg);
            end
            iter_reg <= iter_reg + 1'b1;
        end
        if (cmd.dwell_upd) begin
            rate_reg <= '0;
            if (near) begin
                done_reg <= (elapsed >= cfg.dwell_ms);
            end else begin
                done_reg <= 1'b0;
            end
        end else if (cmd.rate_load) begin
            rate_reg <= rate_sat;
        end
        if (cmd.out_load) begin
            out_data_reg <= {7'd0, done_reg, cfg.drive_speed, rate_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dwell_active_reg <= 1'b0;
            dwell_start_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cmd.dwell_upd) begin
                if (near) begin
                    if (!dwell_active_reg) begin
                        dwell_active_reg <= 1'b1;
                        dwell_start_reg  <= ts_reg;
                    end
                end else begin
                    dwell_active_reg <= 1'b0;
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.far         = far_reg;
    assign sts.cordic_last = (iter_reg == ITER_LAST);
    assign sts.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `ASSERT_NEXT(a_out_valid, aclk, aresetn, cmd.out_load, m_tvalid)
    `ASSERT_NEXT(a_rot_acc, aclk, aresetn, cmd.cordic_init, (acc_reg == '0) || (acc_reg == HALF_TURN))
    `ASSERT_NEXT(a_leave_done, aclk, aresetn, cmd.dwell_upd && !near, !dwell_active_reg && !done_reg)

endmodule

`default_nettype wire

@@ rtl/waypoint_heading_controller.sv @@
// Top level of the waypoint heading controller: registers, controller and datapath.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata: pos_x, pos_y, heading, timestamp_ms
//  m_        out  m_tvalid/m_tready  m_tdata: turn_rate, forward_speed, done_res
//  apb       in   psel/penable       paddr 4*index, pwdata/prdata 32 bits, pready high
//
// One word in at a time. Outside the slow radius a word passes through the square, dwell,
// CORDIC, gain, saturate and output states before the next accept; inside it, CORDIC,
// gain and saturate are skipped. The squares and the gain share one multiplier,
// one product a cycle. The result sits in an output register, so a stalled m_ side holds
// the next word only in its final step. Reset is synchronous, active low.
`default_nettype none

module waypoint_heading_controller
    import whc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // [23:0] pos_x, [47:24] pos_y, [63:48] heading, [95:64] timestamp_ms
    input  wire logic [IN_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // [15:0] turn_rate, [31:16] forward_speed, [32] done_res, [39:33] zero
    output logic      [OUT_W-1:0]  m_tdata,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    whc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    whc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    whc_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .cfg             (cfg),
        .in_pos_x        (s_tdata[23:0]),
        .in_pos_y        (s_tdata[47:24]),
        .in_heading      (s_tdata[63:48]),
        .in_timestamp_ms (s_tdata[95:64]),
        .sts             (sts),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the waypoint heading controller.
`default_nettype none

module testbench;
    import whc_pkg::*;

    localparam int BEARING_ITERS = (CORDIC_STEPS_DEF > CORDIC_MAX) ? CORDIC_MAX
                                                                     : CORDIC_STEPS_DEF;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = CORDIC_STEPS_DEF + 16;
    localparam logic [2:0] REG_SPARE = 3'd7;  // no register decodes here

    // pose word as laid out on s_tdata, lowest field last
    typedef struct packed {
        logic        [TS_W-1:0]  stamp;
        logic signed [ANG_W-1:0] heading;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_x;
    } pose_t;

    typedef struct packed {
        logic                      done_res;
        logic signed [SPEED_W-1:0] forward_speed;
        logic signed [ANG_W-1:0]   turn_rate;
    } steer_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0] pwdata   = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    pose_t  pose_q[$];
    steer_t steer_q[$];
    cfg_t   shadow;
    logic   dwell_on;
    logic [TS_W-1:0] dwell_t0;
    bit     steady = 1'b0;
    int     mismatches = 0;
    int     stall_cycles = 0;

    // atan(2^-i) with 2^32 per full turn
    logic [ACC_W-1:0] atan_step [24] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    waypoint_heading_controller #(
        .CORDIC_STEPS(CORDIC_STEPS_DEF)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // vectoring CORDIC, bearing rounded to a 16-bit binary angle
    function automatic logic [ANG_W-1:0] bearing16(input longint ex, input longint ey);
        logic [ACC_W-1:0] acc;
        longint xs, ys;
        acc = '0;
        if (ex < 0) begin
            ex  = -ex;
            ey  = -ey;
            acc = HALF_TURN;
        end
        for (int i = 0; i < BEARING_ITERS; i++) begin
            xs = ex >>> i;
            ys = ey >>> i;
            if (ey >= 0) begin
                ex  = ex + ys;
                ey  = ey - xs;
                acc = acc + atan_step[i];
            end else begin
                ex  = ex - ys;
                ey  = ey + xs;
                acc = acc - atan_step[i];
            end
        end
        acc = acc + 32'h0000_8000;
        return acc[31:16];
    endfunction

    // steering command for one pose; advances the dwell timer
    function automatic steer_t steer_predict(input pose_t p);
        longint dx, dy, d2, prod;
        logic [ANG_W-1:0] diff;
        logic [TS_W-1:0]  elapsed;
        steer_t r;
        dx = longint'(shadow.target_x) - longint'(p.pos_x);
        dy = longint'(shadow.target_y) - longint'(p.pos_y);
        d2 = dx * dx + dy * dy;
        r.turn_rate = '0;
        r.done_res  = 1'b0;
        if (d2 > longint'(shadow.slow_radius) * longint'(shadow.slow_radius)) begin
            diff = bearing16(dx, dy) - p.heading;
            prod = (longint'($signed(diff)) * longint'(shadow.theta_gain) + 128) >>> 8;
            if (prod > 32767)
                prod = 32767;
            else if (prod < -32768)
                prod = -32768;
            r.turn_rate = prod[15:0];
        end
        if (d2 <= longint'(shadow.done_radius) * longint'(shadow.done_radius)) begin
            if (!dwell_on) begin
                dwell_on = 1'b1;
                dwell_t0 = p.stamp;
            end
            elapsed    = p.stamp - dwell_t0;
            r.done_res = (elapsed >= shadow.dwell_ms);
        end else begin
            dwell_on = 1'b0;
        end
        r.forward_speed = shadow.drive_speed;
        return r;
    endfunction

    function automatic void note_reg(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            REG_TARGET_X:    shadow.target_x    = value[POS_W-1:0];
            REG_TARGET_Y:    shadow.target_y    = value[POS_W-1:0];
            REG_THETA_GAIN:  shadow.theta_gain  = value[GAIN_W-1:0];
            REG_DRIVE_SPEED: shadow.drive_speed = value[SPEED_W-1:0];
            REG_SLOW_RADIUS: shadow.slow_radius = value[RAD_W-1:0];
            REG_DONE_RADIUS: shadow.done_radius = value[RAD_W-1:0];
            REG_DWELL_MS:    shadow.dwell_ms    = value;
            default: ;
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        note_reg(idx, value);
    endtask

    task automatic set_config(input logic [31:0] tx, input logic [31:0] ty,
                              input logic [31:0] gain, input logic [31:0] speed,
                              input logic [31:0] slow_r, input logic [31:0] done_r,
                              input logic [31:0] dwell);
        write_reg(REG_TARGET_X, tx);
        write_reg(REG_TARGET_Y, ty);
        write_reg(REG_THETA_GAIN, gain);
        write_reg(REG_DRIVE_SPEED, speed);
        write_reg(REG_SLOW_RADIUS, slow_r);
        write_reg(REG_DONE_RADIUS, done_r);
        write_reg(REG_DWELL_MS, dwell);
    endtask

    function automatic void push_pose(input int x, input int y, input int h,
                                      input logic [31:0] ts);
        pose_t p;
        p.pos_x   = x[POS_W-1:0];
        p.pos_y   = y[POS_W-1:0];
        p.heading = h[ANG_W-1:0];
        p.stamp   = ts;
        pose_q.push_back(p);
    endfunction

    function automatic int near(input logic signed [POS_W-1:0] centre, input int span);
        return int'(centre) + int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // sampled at the falling edge, after all rising-edge updates
    task automatic drain();
        do @(negedge aclk); while (pose_q.size() != 0 || s_tvalid || steer_q.size() != 0);
    endtask

    task automatic note_mismatch(input string field, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 100)
            $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    // pose driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                steer_q.push_back(steer_predict(pose_t'(s_tdata)));
            if (!s_tvalid || s_tready) begin
                if (pose_q.size() != 0 && (steady || $urandom_range(0, 99) >= 9)) begin
                    s_tdata  <= pose_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : check_results
        steer_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[32:0];
                if (steer_q.size() == 0) begin
                    note_mismatch("unexpected word, turn_rate", 0, got.turn_rate);
                end else begin
                    want = steer_q.pop_front();
                    if (got.turn_rate !== want.turn_rate)
                        note_mismatch("turn_rate", want.turn_rate, got.turn_rate);
                    if (got.forward_speed !== want.forward_speed)
                        note_mismatch("forward_speed", want.forward_speed, got.forward_speed);
                    if (got.done_res !== want.done_res)
                        note_mismatch("done_res", want.done_res, got.done_res);
                end
            end
            m_tready <= steady || $urandom_range(0, 99) >= 9;
        end
    end

    // watchdog: cycles with no handshake anywhere
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("waypoint_heading_controller test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int tx, ty, span, pick;
        logic [31:0] stamp, gain, dwell;
        logic [ANG_W-1:0] hdg;

        shadow      = '0;
        shadow.theta_gain = GAIN_RST;
        dwell_on    = 1'b0;
        dwell_t0    = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values: zero radii, zero dwell
        push_pose(0, 0, 0, 0);
        push_pose(24'h800000, 24'h7FFFFF, 16'h8000, 32'hFFFF_FFFF);
        push_pose(24'h7FFFFF, 24'h800000, 16'h7FFF, 0);
        push_pose(1, 0, 16'h4000, 7);
        drain();

        set_config(1000, -2000, 256, 1234, 100, 50, 100);
        hdg = bearing16(1000, -2000) + 16'h8000;
        push_pose(0, 0, hdg, 10);              // error of exactly half a turn
        push_pose(0, -2000, 0, 20);            // target straight ahead on +x
        push_pose(2000, -2000, 0, 30);         // target behind, pre-rotation
        push_pose(1000, -5000, 16'hC000, 40);  // target on +y
        push_pose(1000, 1000, 16'h3FFF, 50);   // target on -y
        push_pose(900, -2000, 0, 60);          // on the slow radius
        push_pose(899, -2000, 0, 70);          // just outside it
        push_pose(1050, -2000, 0, 1000);       // on the done radius, dwell starts
        push_pose(1010, -1990, 0, 1050);
        push_pose(1010, -1990, 0, 1100);       // dwell reached
        push_pose(0, 0, 0, 1200);              // leaves, dwell clears
        push_pose(1000, -2000, 0, 5);          // re-enter, dwell restarts
        push_pose(1000, -2000, 0, 2);          // time goes backwards
        drain();

        set_config(24'h7FFFFF, 24'h800000, 16'hFFFF, 16'h8000, 0, 24'hFFFFFF,
                   32'hFFFF_FFFF);
        push_pose(24'h800000, 24'h7FFFFF, 0, 3);
        push_pose(24'h800000, 24'h7FFFFF, 16'h7FFF, 4);
        push_pose(0, 0, 16'h8000, 5);
        push_pose(24'h7FFFFF, 24'h800000, 0, 0);
        push_pose(24'h7FFFFF, 24'h800000, 0, 32'hFFFF_FFFF);
        drain();

        set_config(24'h800000, 24'h7FFFFF, 0, 16'h7FFF, 24'hFFFFFF, 0, 0);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        push_pose(24'h7FFFFF, 24'h800000, 16'h1234, 9);
        push_pose(24'h800000, 24'h7FFFFF, 16'h1234, 9);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            tx    = $urandom();
            ty    = $urandom();
            gain  = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1024);
            dwell = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
            set_config(tx, ty, gain, $urandom(), $urandom_range(0, 600),
                       $urandom_range(0, 400), dwell);
            stamp  = $urandom();
            steady = (ph == 2);
            for (int k = 0; k < 110; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // approach and loiter near the target, time moving forward
                    span = (pick < 55) ? shadow.done_radius * 3 / 4
                                       : shadow.done_radius * 3 / 2 + 20;
                    stamp = stamp + $urandom_range(0, 50);
                    push_pose(near(shadow.target_x, span), near(shadow.target_y, span),
                              $urandom(), stamp);
                end else if (pick < 88) begin
                    stamp = stamp + $urandom_range(0, 1000);
                    push_pose(near(shadow.target_x, 65536), near(shadow.target_y, 65536),
                              $urandom(), stamp);
                end else begin
                    push_pose($urandom(), $urandom(), $urandom(), $urandom());
                end
            end
            drain();
        end
        steady = 1'b0;

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("waypoint_heading_controller test passed");
        else
            $display("waypoint_heading_controller test failed");
        $finish;
    end

endmodule

`default_nettype wire
